// ===== src/belt_block_cipher_core_macros.svh =====
// ----------------------------------------------------------------------------
// belt block cipher core assertion macros
// shared property shapes for the core checks, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BELT_BLOCK_CIPHER_CORE_MACROS_SVH
`define BELT_BLOCK_CIPHER_CORE_MACROS_SVH

// condition holds in the same cycle
`define BBC_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the next cycle
`define BBC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// types, s-box and round step functions of the belt block cipher core
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int NUM_ROUNDS      = 8;
  localparam int STEPS_PER_ROUND = 5;
  localparam int NUM_STEPS       = NUM_ROUNDS * STEPS_PER_ROUND;
  localparam int NUM_KEY_WORDS   = 8;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [4:0] ROT_5  = 5'd5;
  localparam logic [4:0] ROT_13 = 5'd13;
  localparam logic [4:0] ROT_21 = 5'd21;

  // one pipeline slot per g level of a round
  typedef enum logic [2:0] {
    STEP_BC_IN  = 3'd0,
    STEP_A_SUB  = 3'd1,
    STEP_E_MIX  = 3'd2,
    STEP_D_ADD  = 3'd3,
    STEP_BC_OUT = 3'd4
  } bbc_step_t;

  typedef logic [NUM_KEY_WORDS-1:0][31:0] bbc_key_t;
  typedef logic [3:0][31:0]               bbc_words_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } bbc_blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hB1, 8'h94, 8'hBA, 8'hC8, 8'h0A, 8'h08, 8'hF5, 8'h3B,
    8'h36, 8'h6D, 8'h00, 8'h8E, 8'h58, 8'h4A, 8'h5D, 8'hE4,
    8'h85, 8'h04, 8'hFA, 8'h9D, 8'h1B, 8'hB6, 8'hC7, 8'hAC,
    8'h25, 8'h2E, 8'h72, 8'hC2, 8'h02, 8'hFD, 8'hCE, 8'h0D,
    8'h5B, 8'hE3, 8'hD6, 8'h12, 8'h17, 8'hB9, 8'h61, 8'h81,
    8'hFE, 8'h67, 8'h86, 8'hAD, 8'h71, 8'h6B, 8'h89, 8'h0B,
    8'h5C, 8'hB0, 8'hC0, 8'hFF, 8'h33, 8'hC3, 8'h56, 8'hB8,
    8'h35, 8'hC4, 8'h05, 8'hAE, 8'hD8, 8'hE0, 8'h7F, 8'h99,
    8'hE1, 8'h2B, 8'hDC, 8'h1A, 8'hE2, 8'h82, 8'h57, 8'hEC,
    8'h70, 8'h3F, 8'hCC, 8'hF0, 8'h95, 8'hEE, 8'h8D, 8'hF1,
    8'hC1, 8'hAB, 8'h76, 8'h38, 8'h9F, 8'hE6, 8'h78, 8'hCA,
    8'hF7, 8'hC6, 8'hF8, 8'h60, 8'hD5, 8'hBB, 8'h9C, 8'h4F,
    8'hF3, 8'h3C, 8'h65, 8'h7B, 8'h63, 8'h7C, 8'h30, 8'h6A,
    8'hDD, 8'h4E, 8'hA7, 8'h79, 8'h9E, 8'hB2, 8'h3D, 8'h31,
    8'h3E, 8'h98, 8'hB5, 8'h6E, 8'h27, 8'hD3, 8'hBC, 8'hCF,
    8'h59, 8'h1E, 8'h18, 8'h1F, 8'h4C, 8'h5A, 8'hB7, 8'h93,
    8'hE9, 8'hDE, 8'hE7, 8'h2C, 8'h8F, 8'h0C, 8'h0F, 8'hA6,
    8'h2D, 8'hDB, 8'h49, 8'hF4, 8'h6F, 8'h73, 8'h96, 8'h47,
    8'h06, 8'h07, 8'h53, 8'h16, 8'hED, 8'h24, 8'h7A, 8'h37,
    8'h39, 8'hCB, 8'hA3, 8'h83, 8'h03, 8'hA9, 8'h8B, 8'hF6,
    8'h92, 8'hBD, 8'h9B, 8'h1C, 8'hE5, 8'hD1, 8'h41, 8'h01,
    8'h54, 8'h45, 8'hFB, 8'hC9, 8'h5E, 8'h4D, 8'h0E, 8'hF2,
    8'h68, 8'h20, 8'h80, 8'hAA, 8'h22, 8'h7D, 8'h64, 8'h2F,
    8'h26, 8'h87, 8'hF9, 8'h34, 8'h90, 8'h40, 8'h55, 8'h11,
    8'hBE, 8'h32, 8'h97, 8'h13, 8'h43, 8'hFC, 8'h9A, 8'h48,
    8'hA0, 8'h2A, 8'h88, 8'h5F, 8'h19, 8'h4B, 8'h09, 8'hA1,
    8'h7E, 8'hCD, 8'hA4, 8'hD0, 8'h15, 8'h44, 8'hAF, 8'h8C,
    8'hA5, 8'h84, 8'h50, 8'hBF, 8'h66, 8'hD2, 8'hE8, 8'h8A,
    8'hA2, 8'hD7, 8'h46, 8'h52, 8'h42, 8'hA8, 8'hDF, 8'hB3,
    8'h69, 8'h74, 8'hC5, 8'h51, 8'hEB, 8'h23, 8'h29, 8'h21,
    8'hD4, 8'hEF, 8'hD9, 8'hB4, 8'h3A, 8'h62, 8'h28, 8'h75,
    8'h91, 8'h14, 8'h10, 8'hEA, 8'h77, 8'h6C, 8'hDA, 8'h1D
  };

  // s-box on every byte, then rotate left
  function automatic logic [31:0] bbc_g(logic [31:0] x, logic [4:0] rot);
    logic [31:0] y;
    logic [63:0] dbl;
    y   = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    dbl = {y, y} << rot;
    return dbl[63:32];
  endfunction

  // key word k of the round at pipeline position rpos; decrypt runs rounds
  // backwards and takes the key words of a round in reverse order
  function automatic logic [31:0] bbc_rkey(bbc_key_t key, logic dec,
                                           logic [2:0] rpos, logic [2:0] k);
    logic [2:0] kk;
    logic [2:0] base;
    logic [2:0] idx;
    kk   = dec ? (3'd6 - k) : k;
    base = dec ? (3'd7 - rpos) : rpos;
    // 7 * base mod 8 is -base mod 8
    idx  = (3'd0 - base) + kk;
    return key[idx];
  endfunction

  function automatic bbc_blk_t bbc_step(bbc_blk_t s, bbc_step_t st,
                                        logic [2:0] rpos, bbc_key_t key);
    logic        dec;
    logic [3:0]  rnum;
    logic [31:0] e;
    logic [31:0] bn;
    logic [31:0] cn;
    bbc_blk_t    n;
    n    = s;
    dec  = (s.cmd == CMD_DECRYPT);
    rnum = dec ? (4'd8 - {1'b0, rpos}) : ({1'b0, rpos} + 4'd1);
    e    = '0;
    bn   = '0;
    cn   = '0;
    case (st)
      STEP_BC_IN: begin
        n.b = s.b ^ bbc_g(s.a + bbc_rkey(key, dec, rpos, 3'd0), ROT_5);
        n.c = s.c ^ bbc_g(s.d + bbc_rkey(key, dec, rpos, 3'd1), ROT_21);
      end
      STEP_A_SUB: begin
        n.a = s.a - bbc_g(s.b + bbc_rkey(key, dec, rpos, 3'd2), ROT_13);
      end
      STEP_E_MIX: begin
        e   = bbc_g(s.b + s.c + bbc_rkey(key, dec, rpos, 3'd3), ROT_21)
              ^ {28'd0, rnum};
        n.b = s.b + e;
        n.c = s.c - e;
      end
      STEP_D_ADD: begin
        n.d = s.d + bbc_g(s.c + bbc_rkey(key, dec, rpos, 3'd4), ROT_13);
      end
      STEP_BC_OUT: begin
        bn = s.b ^ bbc_g(s.a + bbc_rkey(key, dec, rpos, 3'd5), ROT_21);
        cn = s.c ^ bbc_g(s.d + bbc_rkey(key, dec, rpos, 3'd6), ROT_5);
        // end of round word swap differs by direction
        if (dec) begin
          n.a = cn;
          n.b = s.a;
          n.c = s.d;
          n.d = bn;
        end else begin
          n.a = bn;
          n.b = s.d;
          n.c = s.a;
          n.d = cn;
        end
      end
      default: n = s;
    endcase
    return n;
  endfunction

  // final word order of the result block
  function automatic bbc_words_t bbc_result(bbc_blk_t s);
    bbc_words_t w;
    if (s.cmd == CMD_DECRYPT) begin
      w[0] = s.c;
      w[1] = s.a;
      w[2] = s.d;
      w[3] = s.b;
    end else begin
      w[0] = s.b;
      w[1] = s.d;
      w[2] = s.a;
      w[3] = s.c;
    end
    return w;
  endfunction

endpackage

// ===== src/belt_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// belt_block_cipher_core
// belt (stb 34.101.31) block encrypt/decrypt, 256-bit key, fully pipelined
// ----------------------------------------------------------------------------
//  channel   direction  signals                              handshake
//  input     in         in_cmd, in_word_0..3                 in_valid / in_stall
//  result    out        out_word_0..3                        out_valid / out_stall
//  config    apb        psel penable pwrite paddr pwdata     pready tied high
//
//  one block per cycle while in_stall is low; out_valid follows the accepting
//  edge through the input register, 40 g-level stages and the output register
//  the eight rounds are unrolled, each round split into five g-level stages
//  reset clears the valid bits, the output/skid flags and the key words
//  a pipe word that meets a held output parks in a skid register; in_stall is
//  the skid flag and freezes the whole pipeline, nothing is dropped or repeated
// ----------------------------------------------------------------------------
`include "belt_block_cipher_core_macros.svh"

module belt_block_cipher_core
  import bbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_word_0,
  input  logic [31:0] in_word_1,
  input  logic [31:0] in_word_2,
  input  logic [31:0] in_word_3,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word_0,
  output logic [31:0] out_word_1,
  output logic [31:0] out_word_2,
  output logic [31:0] out_word_3,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // key registers, written over apb at byte address 4*i
  bbc_key_t key_r;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = key_r[paddr[4:2]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr) begin
      key_r[paddr[4:2]] <= pwdata;
    end
  end

  // pipeline, frozen while the skid register is occupied
  logic       skid_full_r;
  logic       pipe_en;
  logic       pipe_valid;
  bbc_words_t pipe_words;
  bbc_blk_t   in_blk;

  assign pipe_en = !skid_full_r;
  assign in_blk  = '{cmd: in_cmd, a: in_word_0, b: in_word_1, c: in_word_2, d: in_word_3};

  bbc_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_valid),
    .in_blk    (in_blk),
    .key       (key_r),
    .out_valid (pipe_valid),
    .out_words (pipe_words)
  );

  // output register plus one skid slot
  logic       out_valid_r;
  logic       out_valid_nxt;
  bbc_words_t out_words_r;
  bbc_words_t out_words_nxt;
  logic       skid_full_nxt;
  bbc_words_t skid_words_r;
  bbc_words_t skid_words_nxt;
  logic       out_fire;
  logic       pipe_take;

  assign out_fire  = out_valid_r && !out_stall;
  assign pipe_take = pipe_en && pipe_valid;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_words_nxt  = out_words_r;
    skid_full_nxt  = skid_full_r;
    skid_words_nxt = skid_words_r;
    if (skid_full_r) begin
      // pipeline is frozen, drain the parked word first
      if (out_fire) begin
        out_words_nxt = skid_words_r;
        skid_full_nxt = 1'b0;
      end
    end else if (pipe_take) begin
      if (!out_valid_r || out_fire) begin
        out_valid_nxt = 1'b1;
        out_words_nxt = pipe_words;
      end else begin
        // output still held, park the word that just left the pipe
        skid_full_nxt  = 1'b1;
        skid_words_nxt = pipe_words;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_words_r  <= out_words_nxt;
    skid_words_r <= skid_words_nxt;
  end

  assign in_stall   = skid_full_r;
  assign out_valid  = out_valid_r;
  assign out_word_0 = out_words_r[0];
  assign out_word_1 = out_words_r[1];
  assign out_word_2 = out_words_r[2];
  assign out_word_3 = out_words_r[3];

  // checks
  `BBC_ASSERT_SAME(a_skid_needs_out, skid_full_r, out_valid_r,
    "skid word without output word")
  `BBC_ASSERT_NEXT(a_skid_fills,
    out_valid_r && out_stall && pipe_valid && !skid_full_r, skid_full_r,
    "pipe word lost while output stalled")
  `BBC_ASSERT_NEXT(a_skid_drains, skid_full_r && !out_stall,
    !skid_full_r && out_valid_r, "skid word not moved to output")

endmodule

// ===== src/bbc_pipe.sv =====
// ----------------------------------------------------------------------------
// bbc_pipe
// unrolled round pipeline, one g level per stage, five stages per round
// ----------------------------------------------------------------------------
module bbc_pipe
  import bbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  bbc_blk_t   in_blk,
  input  bbc_key_t   key,
  output logic       out_valid,
  output bbc_words_t out_words
);

  logic [NUM_STEPS:0] valid_r;
  bbc_blk_t           blk_r [NUM_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NUM_STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_r[0] <= in_blk;
    end
  end

  for (genvar j = 0; j < NUM_STEPS; j++) begin : g_stage
    localparam bbc_step_t  STEP = bbc_step_t'(j % STEPS_PER_ROUND);
    localparam logic [2:0] RPOS = 3'(j / STEPS_PER_ROUND);

    always_ff @(posedge clk) begin
      if (en) begin
        blk_r[j+1] <= bbc_step(blk_r[j], STEP, RPOS, key);
      end
    end
  end

  assign out_valid = valid_r[NUM_STEPS];
  assign out_words = bbc_result(blk_r[NUM_STEPS]);

endmodule
